### hw/rtl/ffha_pkg.sv
// ffha_pkg: shared types and constants for the first-fit heap allocator
// no dependencies; imported by the allocator top level and its checker

package ffha_pkg;

    // fixed field widths of the request and response words
    localparam int SIZE_W = 17;
    localparam int ADDR_W = 16;
    localparam int STAT_W = 2;
    localparam int REQ_W  = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] LIMIT_RESET = 17'h10000;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // response status codes
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OOM  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_UNLINK,
        S_SPLIT,
        S_BUMP,
        S_FREE,
        S_RESP
    } t_state;

endpackage

### hw/rtl/ffha_hdr_ram.sv
// ffha_hdr_ram: one-write one-read synchronous memory for chunk header fields
// no dependencies; instanced twice by the allocator top level

module ffha_hdr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/first_fit_heap_allocator_top.sv
// first_fit_heap_allocator_top: first-fit free-list heap allocator
// uses ffha_pkg and two ffha_hdr_ram instances for chunk size and link headers
//
// Usage:
//   request channel (i_in_valid / o_in_stall) carries one word: i_req_type,
//   i_byte_count for allocate, i_block_addr for free. response channel
//   (o_out_valid / i_out_stall) returns one word per request: o_status and
//   o_payload_addr. i_cfg_we / i_cfg_data write heap_limit; the user must
//   write it only while idle, which the block itself does not enforce. One
//   request is worked on at a time; the walk over the free list reads one
//   header per cycle from the size and link memories (one read port each).
//   A free passes S_FREE and a zero-size allocate goes straight to S_RESP;
//   an allocate walks the list (S_WALK), then S_UNLINK and S_SPLIT when the
//   chunk is split; a walk that reaches the list end or skips 8192 chunks
//   finds nothing and tries to grow the heap instead (S_BUMP).
//   The next request is taken the cycle after the response is loaded, so a
//   finished response may wait in the output register while work goes on.
//   A stalled receiver holds the response; a second response waits inside.
//   Reset empties the free list, zeroes the heap top and sets heap_limit to
//   65536; header memories are not cleared and need no clearing pass.

module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [SIZE_W-1:0] i_byte_count,
    input  logic [ADDR_W-1:0] i_block_addr,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [ADDR_W-1:0] o_payload_addr,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam int DEPTH = HEAP_BYTES / 8;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (($clog2(HEAP_BYTES) > REQ_W) ? $clog2(HEAP_BYTES) : REQ_W) + 2;

    localparam logic [IW-1:0]    NULL_IDX = IW'(DEPTH);
    localparam logic [CMP_W-1:0] HDR      = CMP_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] MIN_LEFT = CMP_W'(HEADER_BYTES + 8);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);
    localparam logic [CMP_W-1:0] HEAP_C   = CMP_W'(HEAP_BYTES);

    t_state r_state, n_state;

    logic [IW-1:0]     r_free_head, n_free_head;
    logic [SIZE_W-1:0] r_heap_top, n_heap_top;
    logic [SIZE_W-1:0] r_heap_limit;

    logic [REQ_W-1:0]  r_request, n_request;
    logic [ADDR_W-1:0] r_block_addr, n_block_addr;
    logic [IW-1:0]     r_cur, n_cur;
    logic [IW-1:0]     r_prev, n_prev;
    logic [IW-1:0]     r_steps, n_steps;
    logic [SIZE_W-1:0] r_size_cur, n_size_cur;
    logic [IW-1:0]     r_link_cur, n_link_cur;
    logic [AW-1:0]     r_split_idx, n_split_idx;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;

    // memory ports
    logic [AW-1:0]     rd_addr;
    logic              size_we;
    logic [AW-1:0]     size_waddr;
    logic [SIZE_W-1:0] size_wdata;
    logic [SIZE_W-1:0] size_q;
    logic              link_we;
    logic [AW-1:0]     link_waddr;
    logic [IW-1:0]     link_wdata;
    logic [IW-1:0]     link_q;

    logic              in_acc;
    logic              out_free;
    logic              walk_end;
    logic              walk_fit;
    logic [SIZE_W-1:0] leftover;
    logic [CMP_W-1:0]  cur_byte;
    logic [CMP_W-1:0]  split_addr;
    logic              split_ok;
    logic [CMP_W-1:0]  base;
    logic [CMP_W-1:0]  total;
    logic [CMP_W-1:0]  grown;
    logic [CMP_W-1:0]  cap;
    logic              bump_ok;
    logic [CMP_W-1:0]  ptr_w;
    logic [CMP_W-1:0]  hdr_w;
    logic              free_ok;
    logic [REQ_W-1:0]  rounded;

    ffha_hdr_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (DEPTH)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_waddr),
        .i_wdata (size_wdata),
        .i_raddr (rd_addr),
        .o_rdata (size_q)
    );

    ffha_hdr_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_q)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // round the byte count up to a multiple of 8
    assign rounded = (REQ_W'(i_byte_count) + REQ_W'(7)) & ~REQ_W'(7);

    // walk: memory data belongs to r_cur
    assign walk_end = (r_cur >= NULL_IDX) || (r_steps >= NULL_IDX);
    assign walk_fit = (REQ_W'(size_q) >= r_request);

    // split of the chosen chunk
    assign leftover   = SIZE_W'(REQ_W'(r_size_cur) - r_request);
    assign cur_byte   = CMP_W'(r_cur) << 3;
    assign split_addr = cur_byte + HDR + CMP_W'(r_request);
    assign split_ok   = (CMP_W'(leftover) >= MIN_LEFT) && ((split_addr >> 3) < DEPTH_C);

    // heap growth
    assign base    = CMP_W'(r_heap_top);
    assign total   = HDR + CMP_W'(r_request);
    assign grown   = base + total;
    assign cap     = (CMP_W'(r_heap_limit) < HEAP_C) ? CMP_W'(r_heap_limit) : HEAP_C;
    assign bump_ok = (grown <= cap) && ((base >> 3) < DEPTH_C);

    // free address checks
    assign ptr_w   = CMP_W'(r_block_addr);
    assign hdr_w   = ptr_w - HDR;
    assign free_ok = (r_block_addr != '0) && (ptr_w >= HDR) && (hdr_w[2:0] == 3'b000)
                     && ((hdr_w >> 3) < DEPTH_C);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_FREE) begin
                        n_state = S_FREE;
                    end else if (i_byte_count == '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    n_state = S_BUMP;
                end else if (walk_fit) begin
                    n_state = S_UNLINK;
                end
            end
            S_UNLINK: begin
                n_state = split_ok ? S_SPLIT : S_RESP;
            end
            S_SPLIT: n_state = S_RESP;
            S_BUMP:  n_state = S_RESP;
            S_FREE:  n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_heap_top   = r_heap_top;
        n_request    = r_request;
        n_block_addr = r_block_addr;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_size_cur   = r_size_cur;
        n_link_cur   = r_link_cur;
        n_split_idx  = r_split_idx;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        rd_addr      = r_cur[AW-1:0];
        size_we      = 1'b0;
        size_waddr   = r_cur[AW-1:0];
        size_wdata   = '0;
        link_we      = 1'b0;
        link_waddr   = r_cur[AW-1:0];
        link_wdata   = '0;

        case (r_state)
            S_IDLE: begin
                rd_addr = r_free_head[AW-1:0];
                if (in_acc) begin
                    n_request    = rounded;
                    n_block_addr = i_block_addr;
                    n_cur        = r_free_head;
                    n_prev       = NULL_IDX;
                    n_steps      = '0;
                    n_res_addr   = '0;
                    n_res_status = (i_req_type == REQ_ALLOC && i_byte_count == '0)
                                   ? STATUS_ZERO : STATUS_OK;
                end
            end
            S_WALK: begin
                if (!walk_end) begin
                    if (walk_fit) begin
                        n_size_cur = size_q;
                        n_link_cur = link_q;
                    end else begin
                        // follow the link straight into the next read
                        n_prev  = r_cur;
                        n_cur   = link_q;
                        n_steps = r_steps + IW'(1);
                        rd_addr = link_q[AW-1:0];
                    end
                end
            end
            S_UNLINK: begin
                if (r_prev < NULL_IDX) begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[AW-1:0];
                    link_wdata = r_link_cur;
                end else begin
                    n_free_head = r_link_cur;
                end
                if (split_ok) begin
                    size_we     = 1'b1;
                    size_waddr  = split_addr[AW+2:3];
                    size_wdata  = SIZE_W'(CMP_W'(leftover) - HDR);
                    n_split_idx = split_addr[AW+2:3];
                end
                n_res_status = STATUS_OK;
                n_res_addr   = ADDR_W'(cur_byte + HDR);
            end
            S_SPLIT: begin
                // push the tail and trim the chosen chunk
                link_we     = 1'b1;
                link_waddr  = r_split_idx;
                link_wdata  = r_free_head;
                n_free_head = IW'(r_split_idx);
                size_we     = 1'b1;
                size_waddr  = r_cur[AW-1:0];
                size_wdata  = SIZE_W'(r_request);
            end
            S_BUMP: begin
                if (bump_ok) begin
                    size_we      = 1'b1;
                    size_waddr   = base[AW+2:3];
                    size_wdata   = SIZE_W'(r_request);
                    link_we      = 1'b1;
                    link_waddr   = base[AW+2:3];
                    link_wdata   = NULL_IDX;
                    n_heap_top   = SIZE_W'(grown);
                    n_res_status = STATUS_OK;
                    n_res_addr   = ADDR_W'(base + HDR);
                end else begin
                    n_res_status = STATUS_OOM;
                    n_res_addr   = '0;
                end
            end
            S_FREE: begin
                if (free_ok) begin
                    link_we     = 1'b1;
                    link_waddr  = hdr_w[AW+2:3];
                    link_wdata  = r_free_head;
                    n_free_head = IW'(hdr_w[AW+2:3]);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= NULL_IDX;
            r_heap_top   <= '0;
            r_heap_limit <= LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_heap_top  <= n_heap_top;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_heap_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_request    <= n_request;
        r_block_addr <= n_block_addr;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_size_cur   <= n_size_cur;
        r_link_cur   <= n_link_cur;
        r_split_idx  <= n_split_idx;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_payload_addr = r_out_addr;

endmodule

### hw/rtl/ffha_checker.sv
// ffha_checker: port-level assertions for the first-fit heap allocator
// uses ffha_pkg; bound to first_fit_heap_allocator_top at the end of this file

module ffha_checker
    import ffha_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [STAT_W-1:0] o_status,
    input logic [ADDR_W-1:0] o_payload_addr
);

    // a held response word keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
                                       && $stable(o_payload_addr))
        else $error("response word changed while stalled");

    // one request at a time: after a word is taken the request side stalls
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one still in work");

    // only a successful allocate carries an address
    a_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STATUS_OK) |-> (o_payload_addr == '0))
        else $error("address returned with a failure status");

    // payload addresses are 8-byte aligned
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_addr[2:0] == 3'b000))
        else $error("misaligned payload address");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);

### sim/tb.sv
// tb: self-checking testbench for first_fit_heap_allocator_top
// depends on ffha_pkg and the allocator RTL; keeps its own heap model to predict each reply

`timescale 1ns / 100ps

module tb
    import ffha_pkg::*;
;

    localparam int HEAP_BYTES = 65536;
    localparam int HDR_BYTES  = 16;
    localparam int DEPTH      = HEAP_BYTES / 8;
    localparam int NULL_IDX   = DEPTH;
    localparam int LINK_W     = $clog2(DEPTH) + 1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_req_type;
    logic [SIZE_W-1:0] i_byte_count;
    logic [ADDR_W-1:0] i_block_addr;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [STAT_W-1:0] o_status;
    logic [ADDR_W-1:0] o_payload_addr;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    first_fit_heap_allocator_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_byte_count   (i_byte_count),
        .i_block_addr   (i_block_addr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_payload_addr (o_payload_addr),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // heap model state
    bit [SIZE_W-1:0] hdr_size [DEPTH];
    bit [LINK_W-1:0] hdr_link [DEPTH];
    bit [LINK_W-1:0] free_head;
    bit [SIZE_W-1:0] heap_top;
    bit [SIZE_W-1:0] heap_limit;

    t_reply      pending_replies[$];
    int unsigned live_blocks[$];
    int unsigned last_addr;
    int unsigned next_gap;
    int unsigned out_hold;
    int unsigned n_errors;
    bit          calm_in;
    bit          calm_out;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic void push_free(input int unsigned idx);
        hdr_link[idx] = free_head;
        free_head     = LINK_W'(idx);
    endfunction

    function automatic t_reply model_alloc(input int unsigned bytes);
        t_reply      r;
        int unsigned want;
        int unsigned cur;
        int unsigned prev;
        int unsigned steps;
        int unsigned spare;
        int unsigned split;
        int unsigned cap;
        int unsigned base;
        r.status = STATUS_OK;
        r.addr   = '0;
        if (bytes == 0) begin
            r.status = STATUS_ZERO;
            return r;
        end
        want  = (bytes + 7) / 8 * 8;
        cur   = 32'(free_head);
        prev  = NULL_IDX;
        steps = 0;
        // first fit; a cyclic list gives up after DEPTH hops
        while (cur < DEPTH && steps < DEPTH && 32'(hdr_size[cur]) < want) begin
            prev = cur;
            cur  = 32'(hdr_link[cur]);
            steps++;
        end
        if (cur < DEPTH && steps < DEPTH) begin
            spare = 32'(hdr_size[cur]) - want;
            if (prev < DEPTH) begin
                hdr_link[prev] = hdr_link[cur];
            end else begin
                free_head = hdr_link[cur];
            end
            if (spare >= HDR_BYTES + 8) begin
                split = (cur * 8 + HDR_BYTES + want) / 8;
                // a tail header past the heap end means the chunk goes out whole
                if (split < DEPTH) begin
                    hdr_size[split] = SIZE_W'(spare - HDR_BYTES);
                    push_free(split);
                    hdr_size[cur] = SIZE_W'(want);
                end
            end
            r.addr = ADDR_W'(cur * 8 + HDR_BYTES);
            return r;
        end
        cap  = (32'(heap_limit) < HEAP_BYTES) ? 32'(heap_limit) : HEAP_BYTES;
        base = 32'(heap_top);
        if (base + HDR_BYTES + want > cap || base / 8 >= DEPTH) begin
            r.status = STATUS_OOM;
            return r;
        end
        hdr_size[base / 8] = SIZE_W'(want);
        hdr_link[base / 8] = LINK_W'(NULL_IDX);
        heap_top = SIZE_W'(base + HDR_BYTES + want);
        r.addr   = ADDR_W'(base + HDR_BYTES);
        return r;
    endfunction

    function automatic void model_free(input int unsigned addr);
        // null, low and misaligned pointers are dropped
        if (addr >= HDR_BYTES && ((addr - HDR_BYTES) % 8) == 0
            && (addr - HDR_BYTES) / 8 < DEPTH) begin
            push_free((addr - HDR_BYTES) / 8);
        end
    endfunction

    task automatic send_word(input logic kind, input int unsigned bytes, input int unsigned addr);
        t_reply r;
        repeat (next_gap) @(posedge i_clk);
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        // the field that the request does not use carries junk
        i_byte_count <= (kind == REQ_ALLOC) ? SIZE_W'(bytes) : SIZE_W'($urandom);
        i_block_addr <= (kind == REQ_FREE) ? ADDR_W'(addr) : ADDR_W'($urandom);
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (kind == REQ_ALLOC) begin
            r = model_alloc(bytes);
            if (r.status == STATUS_OK) live_blocks.push_back(32'(r.addr));
        end else begin
            model_free(addr);
            r.status = STATUS_OK;
            r.addr   = '0;
            for (int i = 0; i < live_blocks.size(); i++) begin
                if (live_blocks[i] == addr) begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
        pending_replies.push_back(r);
        last_addr = 32'(r.addr);
        next_gap  = calm_in ? 0 : $urandom_range(0, 11);
        if (next_gap != 0) i_in_valid <= 1'b0;
    endtask

    // hold off the sender until every reply is back
    task automatic quiesce(input int unsigned extra);
        if (next_gap == 0) i_in_valid <= 1'b0;
        next_gap = 0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_heap_limit(input int unsigned value);
        quiesce(6);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= SIZE_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        heap_limit = SIZE_W'(value);
    endtask

    task automatic test_alloc_and_free;
        int unsigned a, b, c;
        send_word(REQ_ALLOC, 0, 0);
        send_word(REQ_ALLOC, 1, 0);
        a = last_addr;
        send_word(REQ_ALLOC, 24, 0);
        b = last_addr;
        send_word(REQ_ALLOC, 100, 0);
        c = last_addr;
        send_word(REQ_ALLOC, 65536, 0);
        send_word(REQ_FREE, 0, 0);
        send_word(REQ_FREE, 0, 7);
        send_word(REQ_FREE, 0, c + 4);
        send_word(REQ_FREE, 0, c);
        // big free chunk gets split, then the tail is reused exactly
        send_word(REQ_ALLOC, 8, 0);
        send_word(REQ_ALLOC, 80, 0);
        send_word(REQ_FREE, 0, a);
        send_word(REQ_FREE, 0, b);
        send_word(REQ_ALLOC, 16, 0);
        send_word(REQ_ALLOC, 32, 0);
        send_word(REQ_ALLOC, 8, 0);
    endtask

    task automatic test_first_fit_walk;
        int unsigned blk[4];
        send_word(REQ_ALLOC, 64, 0);
        blk[0] = last_addr;
        for (int i = 1; i < 4; i++) begin
            send_word(REQ_ALLOC, 8, 0);
            blk[i] = last_addr;
        end
        for (int i = 0; i < 4; i++) send_word(REQ_FREE, 0, blk[i]);
        // skips the three small chunks, leftover just big enough to split
        send_word(REQ_ALLOC, 40, 0);
    endtask

    task automatic test_heap_limit;
        write_heap_limit(0);
        send_word(REQ_ALLOC, 60000, 0);
        write_heap_limit(32'(heap_top) + HDR_BYTES + 64);
        send_word(REQ_ALLOC, 64, 0);
        send_word(REQ_ALLOC, 1000, 0);
        write_heap_limit(17'h1FFFF);
        send_word(REQ_ALLOC, 200, 0);
        write_heap_limit(LIMIT_RESET);
    endtask

    task automatic test_random_traffic(input int unsigned limit, input int unsigned count);
        int unsigned pick;
        int unsigned size;
        write_heap_limit(limit);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) calm_in = ~calm_in;
            if ($urandom_range(0, 39) == 0) calm_out = ~calm_out;
            if (n == count / 2) quiesce(2);
            pick = $urandom_range(0, 99);
            if (pick < 52 || (pick < 88 && live_blocks.size() == 0)) begin
                size = $urandom_range(0, 19);
                if (size < 15) size = $urandom_range(1, 128);
                else if (size < 19) size = $urandom_range(129, 1024);
                else size = $urandom_range(1025, 65536);
                send_word(REQ_ALLOC, size, 0);
            end else if (pick < 88) begin
                send_word(REQ_FREE, 0, live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end else begin
                case (pick % 5)
                    0: send_word(REQ_FREE, 0, 0);
                    1: send_word(REQ_FREE, 0, $urandom_range(1, HDR_BYTES - 1));
                    2: send_word(REQ_FREE, 0,
                                 $urandom_range(2, DEPTH - 1) * 8 + $urandom_range(1, 7));
                    3: send_word(REQ_ALLOC, 0, 0);
                    default: send_word(REQ_ALLOC, 65536, 0);
                endcase
            end
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
    endtask

    // double free leaves a chunk linked to itself; a walk that finds no fit must give up and bump
    task automatic test_cyclic_list;
        int unsigned x, y;
        quiesce(2);
        send_word(REQ_ALLOC, 8, 0);
        x = last_addr;
        send_word(REQ_ALLOC, 8, 0);
        y = last_addr;
        send_word(REQ_FREE, 0, x);
        send_word(REQ_FREE, 0, x);
        send_word(REQ_ALLOC, 1000, 0);
        send_word(REQ_ALLOC, 8, 0);
        send_word(REQ_ALLOC, 8, 0);
        send_word(REQ_FREE, 0, y);
    endtask

    // reply checker and receiver stalls
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n === 1'b1) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected word status %0d addr %0d",
                                              o_status, o_payload_addr));
                end else begin
                    want = pending_replies.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_payload_addr !== want.addr)
                        report_mismatch($sformatf("payload_addr %0d, expected %0d",
                                                  o_payload_addr, want.addr));
                end
                out_hold = calm_out ? 0 : $urandom_range(0, 11);
            end else if (out_hold == 0 && !calm_out && $urandom_range(0, 15) == 0) begin
                out_hold = $urandom_range(1, 11);
            end
            if (out_hold != 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #30_000_000;
        $display("** first_fit_heap_allocator_top: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= REQ_ALLOC;
        i_byte_count <= '0;
        i_block_addr <= '0;
        i_out_stall  <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        free_head    = LINK_W'(NULL_IDX);
        heap_top     = '0;
        heap_limit   = LIMIT_RESET;
        n_errors     = 0;
        next_gap     = 0;
        out_hold     = 0;
        calm_in      = 1'b0;
        calm_out     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_alloc_and_free();
        test_first_fit_walk();
        test_heap_limit();
        test_random_traffic(4096, 200);
        test_random_traffic(16384, 300);
        test_random_traffic($urandom_range(0, 65536), 150);
        test_random_traffic(65536, 500);
        test_cyclic_list();

        quiesce(20);
        if (n_errors == 0) begin
            $display("** first_fit_heap_allocator_top: PASSED **");
        end else begin
            $display("** first_fit_heap_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
